>>> rtl/sfrs_pkg.sv
// Shared types and constants for the serial flash read sequencer.
// No dependencies; imported by every file of the block.
package sfrs_pkg;

    // Read command byte (03h) and a zero filler byte
    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] FILL_BYTE = 8'h00;

    // Input codes for the kind field
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_XFER  = 1'b1;

    // One input request
    typedef struct packed {
        logic        kind;
        logic [23:0] flash_address;
        logic [7:0]  byte_count;
        logic        to_queue;
        logic [7:0]  rx_byte;
    } t_in;

    // One result request
    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       select_active;
        logic       data_valid;
        logic [7:0] data_byte;
        logic [7:0] data_index;
        logic       data_to_queue;
        logic       done_res;
        logic       busy_res;
    } t_out;

endpackage

>>> rtl/sfrs_seq.sv
// Sequencer state and per-request next-state/result logic.
// Depends on sfrs_pkg.
module sfrs_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  sfrs_pkg::t_in  i_in,
    output sfrs_pkg::t_out o_res
);
    import sfrs_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ADDRH,
        PH_ADDRM,
        PH_ADDRL,
        PH_PRE,
        PH_DATA
    } t_phase;

    t_phase      r_phase,    n_phase;
    logic [23:0] r_addr,     n_addr;
    logic [7:0]  r_total,    n_total;
    logic [7:0]  r_pos,      n_pos;
    logic        r_queue,    n_queue;
    logic        r_busy,     n_busy;

    // Next state and result for the request being accepted
    always_comb begin
        n_phase = r_phase;
        n_addr  = r_addr;
        n_total = r_total;
        n_pos   = r_pos;
        n_queue = r_queue;
        n_busy  = r_busy;
        o_res   = '0;

        if (i_in.kind == KIND_START) begin
            // start (or restart): latch request, send command
            n_addr  = i_in.flash_address;
            n_total = i_in.byte_count;
            n_queue = i_in.to_queue;
            n_pos   = 8'd0;
            n_busy  = 1'b1;
            n_phase = PH_ADDRH;
            o_res.tx_valid = 1'b1;
            o_res.tx_byte  = CMD_READ;
        end else begin
            unique case (r_phase)
                PH_ADDRH: begin
                    o_res.tx_valid = 1'b1;
                    o_res.tx_byte  = r_addr[23:16];
                    n_phase        = PH_ADDRM;
                end
                PH_ADDRM: begin
                    o_res.tx_valid = 1'b1;
                    o_res.tx_byte  = r_addr[15:8];
                    n_phase        = PH_ADDRL;
                end
                PH_ADDRL: begin
                    o_res.tx_valid = 1'b1;
                    o_res.tx_byte  = r_addr[7:0];
                    n_phase        = PH_PRE;
                end
                PH_PRE: begin
                    // first filler; received byte belongs to address low
                    o_res.tx_valid = 1'b1;
                    o_res.tx_byte  = FILL_BYTE;
                    n_pos          = 8'd1;
                    n_phase        = PH_DATA;
                end
                PH_DATA: begin
                    o_res.data_valid    = 1'b1;
                    o_res.data_byte     = i_in.rx_byte;
                    o_res.data_index    = r_pos - 8'd1;
                    o_res.data_to_queue = r_queue;
                    // count of zero ends after the position wraps back to zero
                    if (r_pos == r_total) begin
                        o_res.done_res = 1'b1;
                        n_busy         = 1'b0;
                        n_phase        = PH_IDLE;
                    end else begin
                        o_res.tx_valid = 1'b1;
                        o_res.tx_byte  = FILL_BYTE;
                        n_pos          = r_pos + 8'd1;
                    end
                end
                default: begin
                    // transfer while idle is ignored
                end
            endcase
        end

        o_res.select_active = n_busy;
        o_res.busy_res      = n_busy;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_addr  <= '0;
            r_total <= '0;
            r_pos   <= '0;
            r_queue <= 1'b0;
            r_busy  <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_addr  <= n_addr;
            r_total <= n_total;
            r_pos   <= n_pos;
            r_queue <= n_queue;
            r_busy  <= n_busy;
        end
    end

endmodule

>>> rtl/spi_flash_read_sequencer_core.sv
// A result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle; the output register refills in the
// same cycle it is taken, so only a held result stops input.
// Reset (synchronous, active low) returns the sequencer to idle with chip
// select released and empties the output register.
// Top level: input handshake, sequencer state and the result register.
// Depends on sfrs_pkg and sfrs_seq.
module spi_flash_read_sequencer_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sfrs_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output sfrs_pkg::t_out o_out
);
    import sfrs_pkg::*;

    logic r_out_valid;
    t_out r_out;
    t_out w_res;
    logic w_step;

    // Accept when the result register is empty or being drained
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_step     = i_in_valid && o_in_ready;

    sfrs_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_in    (i_in),
        .o_res   (w_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> rtl/sfrs_checker.sv
// Port-level checks for the serial flash read sequencer, bound to the top.
// Depends on sfrs_pkg and spi_flash_read_sequencer_core.
module sfrs_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input sfrs_pkg::t_in  i_in,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input sfrs_pkg::t_out o_out
);
    import sfrs_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // A start request yields the read command next cycle with select asserted
    a_start_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in.kind == KIND_START) |=>
        o_out_valid && o_out.tx_valid && (o_out.tx_byte == CMD_READ) &&
        o_out.select_active && !o_out.data_valid)
        else $error("start request did not send read command");

    // Done releases select and clears busy
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.done_res |->
        o_out.data_valid && !o_out.busy_res && !o_out.select_active &&
        !o_out.tx_valid)
        else $error("done without release of chip select");

    // Chip select follows busy; no data fields without a data byte
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.select_active == o_out.busy_res) &&
        (o_out.data_valid || (o_out.data_byte == 8'd0 &&
        o_out.data_index == 8'd0 && !o_out.data_to_queue)))
        else $error("inconsistent result fields");

endmodule

bind spi_flash_read_sequencer_core sfrs_checker u_sfrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

>>> verif/spi_flash_read_sequencer_core_tb.sv
// Testbench for spi_flash_read_sequencer_core: directed and random read requests
// checked against an in-bench sequencer predictor held in a scoreboard class.
// Depends on sfrs_pkg and the RTL of the block.
module spi_flash_read_sequencer_core_tb;
    import sfrs_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int TARGET_REQUEST = 650;

    // Sequencer position as the predictor tracks it
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_ADDR_HI,
        SEQ_ADDR_MID,
        SEQ_ADDR_LO,
        SEQ_FILL,
        SEQ_DATA
    } t_seq_phase;

    // Predicts the result of each accepted request and checks the results in order
    class flash_read_scoreboard;
        t_seq_phase  phase;
        logic [23:0] read_addr;
        logic [7:0]  read_count;
        logic [7:0]  read_pos;
        logic        queue_dest;
        logic        seq_busy;
        t_out        expected_spi_results[$];
        int          mismatches;
        int          live_requests;
        int          results_seen;

        function new();
            phase         = SEQ_IDLE;
            read_addr     = '0;
            read_count    = '0;
            read_pos      = '0;
            queue_dest    = 1'b0;
            seq_busy      = 1'b0;
            mismatches    = 0;
            live_requests = 0;
            results_seen  = 0;
        endfunction

        // Step the sequencer by one accepted request and queue its result
        function void note_request(t_in r);
            t_out want;
            want = '0;
            if (r.kind == KIND_START || phase != SEQ_IDLE)
                live_requests++;
            if (r.kind == KIND_START) begin
                read_addr     = r.flash_address;
                read_count    = r.byte_count;
                queue_dest    = r.to_queue;
                read_pos      = '0;
                seq_busy      = 1'b1;
                phase         = SEQ_ADDR_HI;
                want.tx_valid = 1'b1;
                want.tx_byte  = CMD_READ;
            end else begin
                case (phase)
                    SEQ_ADDR_HI: begin
                        want.tx_valid = 1'b1;
                        want.tx_byte  = read_addr[23:16];
                        phase         = SEQ_ADDR_MID;
                    end
                    SEQ_ADDR_MID: begin
                        want.tx_valid = 1'b1;
                        want.tx_byte  = read_addr[15:8];
                        phase         = SEQ_ADDR_LO;
                    end
                    SEQ_ADDR_LO: begin
                        want.tx_valid = 1'b1;
                        want.tx_byte  = read_addr[7:0];
                        phase         = SEQ_FILL;
                    end
                    // byte clocked in here is the tail of the address: dropped
                    SEQ_FILL: begin
                        want.tx_valid = 1'b1;
                        want.tx_byte  = FILL_BYTE;
                        read_pos      = 8'd1;
                        phase         = SEQ_DATA;
                    end
                    SEQ_DATA: begin
                        want.data_valid    = 1'b1;
                        want.data_byte     = r.rx_byte;
                        want.data_index    = read_pos - 8'd1;
                        want.data_to_queue = queue_dest;
                        // a count of zero wraps the position round to 256 bytes
                        if (read_pos == read_count) begin
                            want.done_res = 1'b1;
                            seq_busy      = 1'b0;
                            phase         = SEQ_IDLE;
                        end else begin
                            want.tx_valid = 1'b1;
                            want.tx_byte  = FILL_BYTE;
                            read_pos      = read_pos + 8'd1;
                        end
                    end
                    default: ;
                endcase
            end
            want.select_active = seq_busy;
            want.busy_res      = seq_busy;
            expected_spi_results.push_back(want);
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            $display("result %0d: %s got 0x%0h, expected 0x%0h",
                     results_seen, what, got, want);
            mismatches++;
        endtask

        task compare_field(string what, int unsigned got, int unsigned want);
            if (got != want)
                report_mismatch(what, got, want);
        endtask

        task check_result(t_out got);
            t_out want;
            results_seen++;
            if (expected_spi_results.size() == 0) begin
                report_mismatch("unexpected result", got, 0);
            end else begin
                want = expected_spi_results.pop_front();
                compare_field("tx_valid", got.tx_valid, want.tx_valid);
                compare_field("tx_byte", got.tx_byte, want.tx_byte);
                compare_field("select_active", got.select_active, want.select_active);
                compare_field("data_valid", got.data_valid, want.data_valid);
                compare_field("data_byte", got.data_byte, want.data_byte);
                compare_field("data_index", got.data_index, want.data_index);
                compare_field("data_to_queue", got.data_to_queue, want.data_to_queue);
                compare_field("done_res", got.done_res, want.done_res);
                compare_field("busy_res", got.busy_res, want.busy_res);
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out;

    flash_read_scoreboard sb;

    int burst_left;
    int hold_ticket;
    int hold_served;
    int hold_left;
    int ready_run;
    int cycle_count;

    spi_flash_read_sequencer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Accepted requests feed the predictor, accepted results are checked
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            sb.note_request(i_in);
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_out);
    end

    // Receiver: random stall runs, long free runs, and one long hold-off on demand
    always @(posedge i_clk) begin
        if (hold_ticket != hold_served) begin
            hold_served <= hold_ticket;
            hold_left   <= HOLD_OFF_LEN;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (ready_run > 0) begin
            ready_run <= ready_run - 1;
        end else if (i_out_ready) begin
            i_out_ready <= 1'b0;
            ready_run   <= $urandom_range(0, 5);
        end else begin
            i_out_ready <= 1'b1;
            ready_run   <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(0, 10);
        end
    end

    // Offer one request and hold it until taken; bursts end in a short gap
    task send_request(t_in r);
        i_in       <= r;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task send_start(logic [23:0] addr, logic [7:0] count, logic dest);
        t_in r;
        r               = t_in'({$urandom, $urandom});
        r.kind          = KIND_START;
        r.flash_address = addr;
        r.byte_count    = count;
        r.to_queue      = dest;
        send_request(r);
    endtask

    // Unused fields of a transfer carry random bits
    task send_xfer(logic [7:0] rx);
        t_in r;
        r         = t_in'({$urandom, $urandom});
        r.kind    = KIND_XFER;
        r.rx_byte = rx;
        send_request(r);
    endtask

    // One read: start then transfers, sometimes cut short by the next start
    task run_read(logic [7:0] count, bit may_cut);
        int n;
        n = 4 + ((count == 8'd0) ? 256 : int'(count));
        if (may_cut && $urandom_range(0, 6) == 0)
            n = $urandom_range(0, n - 1);
        send_start($urandom_range(0, 24'hFFFFFF), count, $urandom_range(0, 1));
        repeat (n) send_xfer($urandom_range(0, 255));
    endtask

    initial begin
        bit long_read_done;
        bit hold_done;
        logic [7:0] count;

        sb             = new();
        long_read_done = 1'b0;
        hold_done      = 1'b0;
        burst_left     = 1;
        hold_ticket    = 0;
        hold_served    = 0;
        hold_left      = 0;
        ready_run      = 0;
        cycle_count    = 0;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_in           <= '0;
        i_out_ready    <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Transfer while idle is ignored
        send_xfer(8'hFF);
        // Top address, one byte, queue destination
        send_start(24'hFFFFFF, 8'd1, 1'b1);
        repeat (4) send_xfer($urandom_range(0, 255));
        send_xfer(8'hFF);
        send_xfer(8'h00);
        // Bottom address, two bytes, buffer destination
        send_start(24'h000000, 8'd2, 1'b0);
        repeat (4) send_xfer($urandom_range(0, 255));
        send_xfer(8'h00);
        send_xfer(8'hA5);
        // Largest count, then a restart while busy
        send_start(24'h123456, 8'hFF, 1'b1);
        send_xfer(8'h5A);
        send_xfer(8'hC3);
        send_start(24'hABCDEF, 8'd1, 1'b0);
        repeat (5) send_xfer($urandom_range(0, 255));

        // Random reads, mostly short, with a little noise
        while (sb.live_requests < TARGET_REQUEST) begin
            if (!hold_done && sb.live_requests > 300) begin
                hold_ticket <= hold_ticket + 1;
                hold_done = 1'b1;
            end
            if ($urandom_range(0, 99) < 8) begin
                repeat ($urandom_range(1, 3)) send_xfer($urandom_range(0, 255));
            end else if (!long_read_done && sb.live_requests > 100) begin
                // count of zero: a full 256-byte read
                long_read_done = 1'b1;
                run_read(8'd0, 1'b0);
            end else if ($urandom_range(0, 24) == 0) begin
                count = $urandom_range(0, 255);
                run_read(count, $urandom_range(0, 1));
            end else begin
                count = $urandom_range(1, 8);
                run_read(count, 1'b1);
            end
        end

        // Drain; step the clock first so the last accepted request is in the predictor
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_spi_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
